@@ hw/rtl/c2s_pkg.sv @@
// c2s_pkg: shared types and constants for the Cartesian to spherical converter.
// CORDIC angle table, datapath widths and the per-point flag bundle.
`timescale 1ns / 1ps
package c2s_pkg;

  localparam int CORDIC_STAGES = 30;
  localparam int H_ROOT_W      = 32;
  localparam int CORDIC_W      = 36;
  localparam int ACC_W         = 33;
  localparam int ANGLE_W       = 17;
  localparam int ELEV_W        = 16;

  localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 17'sd16384;
  localparam logic signed [ANGLE_W-1:0] QUARTER_M1   = 17'sd16383;
  localparam logic signed [ANGLE_W:0]   HALF_TURN    = 18'sd32768;
  localparam logic signed [ACC_W-1:0]   ROUND_HALF   = 33'sd32768;

  // atan(2^-i), 2^32 units per turn
  localparam logic signed [ACC_W-1:0] ATAN_TAB [0:CORDIC_STAGES-1] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756, 33'sd42667331,
    33'sd21354465,  33'sd10679838,  33'sd5340245,   33'sd2670163,  33'sd1335087,
    33'sd667544,    33'sd333772,    33'sd166886,    33'sd83443,    33'sd41722,
    33'sd20861,     33'sd10430,     33'sd5215,      33'sd2608,     33'sd1304,
    33'sd652,       33'sd326,       33'sd163,       33'sd81,       33'sd41,
    33'sd20,        33'sd10,        33'sd5,         33'sd3,        33'sd1
  };

  typedef struct packed {
    logic signed [CORDIC_W-1:0] a;
    logic signed [CORDIC_W-1:0] b;
    logic signed [ACC_W-1:0]    acc;
  } cordic_t;

  typedef struct packed {
    logic x_zero;
    logic x_neg;
    logic z_zero;
    logic z_neg;
    logic h_zero;
    logic y_zero;
    logic y_neg;
  } flags_t;

endpackage

@@ hw/rtl/c2s_delay.sv @@
// c2s_delay: plain shift register that keeps sideband data in step with the cells.
// No package use.
`timescale 1ns / 1ps
module c2s_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] d_o
);

  logic [WIDTH-1:0] sr_r [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        sr_r[k] <= sr_r[k-1];
      end
    end
  end

  assign d_o = sr_r[DEPTH-1];

endmodule

@@ hw/rtl/c2s_sqrt_cell.sv @@
// c2s_sqrt_cell: one registered digit step of a bit-by-bit integer square root.
// No package use.
`timescale 1ns / 1ps
module c2s_sqrt_cell #(
  parameter int W = 16
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*W-1:0] v_i,
  input  logic [W+2:0]   rem_i,
  input  logic [W-1:0]   root_i,
  output logic [2*W-1:0] v_o,
  output logic [W+2:0]   rem_o,
  output logic [W-1:0]   root_o
);

  localparam int RW = W + 3;

  logic [RW-1:0]  rem_sh;
  logic [RW:0]    diff;
  logic [2*W-1:0] v_nxt, v_r;
  logic [RW-1:0]  rem_nxt, rem_r;
  logic [W-1:0]   root_nxt, root_r;

  always_comb begin
    rem_sh = {rem_i[RW-3:0], v_i[2*W-1 -: 2]};
    diff   = {1'b0, rem_sh} - {1'b0, RW'({root_i, 2'b01})};
    v_nxt  = {v_i[2*W-3:0], 2'b00};
    if (!diff[RW]) begin
      rem_nxt  = diff[RW-1:0];
      root_nxt = {root_i[W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_i[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r    <= v_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign v_o    = v_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

@@ hw/rtl/c2s_cordic_cell.sv @@
// c2s_cordic_cell: one registered CORDIC vectoring micro-rotation.
// Uses c2s_pkg for the state struct and the angle table.
`timescale 1ns / 1ps
module c2s_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             en,
  input  c2s_pkg::cordic_t st_i,
  output c2s_pkg::cordic_t st_o
);

  c2s_pkg::cordic_t st_nxt, st_r;

  always_comb begin
    if (st_i.b >= 0) begin
      st_nxt.a   = st_i.a + (st_i.b >>> IDX);
      st_nxt.b   = st_i.b - (st_i.a >>> IDX);
      st_nxt.acc = st_i.acc + c2s_pkg::ATAN_TAB[IDX];
    end else begin
      st_nxt.a   = st_i.a - (st_i.b >>> IDX);
      st_nxt.b   = st_i.b + (st_i.a >>> IDX);
      st_nxt.acc = st_i.acc - c2s_pkg::ATAN_TAB[IDX];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;

endmodule

@@ hw/rtl/cartesian_to_spherical.sv @@
// cartesian_to_spherical: point (x, y, z) to radius, polar and elevation angle.
// Stages: squares, sums, a 32-cell root chain for the horizontal length, a 30-cell CORDIC
// chain for elevation, final stage; radius root and polar CORDIC chains run alongside.
// Throughput one point per cycle while the skid stage is empty; output register and skid decouple.
// Reset clears only the valid bits; payload registers are not reset.
// Uses c2s_pkg, c2s_delay, c2s_sqrt_cell, c2s_cordic_cell.
`timescale 1ns / 1ps
module cartesian_to_spherical #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_x_coord,
  input  logic signed [COORD_WIDTH-1:0] in_y_coord,
  input  logic signed [COORD_WIDTH-1:0] in_z_coord,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COORD_WIDTH-1:0]        out_radius,
  output logic signed [16:0]            out_polar_angle,
  output logic signed [15:0]            out_elevation_angle,
  output logic                          out_degenerate
);

  localparam int CW   = COORD_WIDTH;
  localparam int G    = 32 - CW;
  localparam int HW   = c2s_pkg::H_ROOT_W;
  localparam int NC   = c2s_pkg::CORDIC_STAGES;
  localparam int DW   = c2s_pkg::CORDIC_W;
  localparam int AW   = c2s_pkg::ACC_W;
  localparam int LAT  = 2 + HW + NC + 1;
  localparam int MID  = HW + NC;
  localparam int RDLY = MID - CW;

  logic adv, in_fire;
  logic skid_v_r;
  logic [LAT-1:0] vld_r;

  assign adv      = !skid_v_r;
  assign in_ready = adv;
  assign in_fire  = in_valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_fire};
    end
  end

  // stage 1: squares
  logic signed [CW-1:0] x_r, y_r, z_r;
  logic [2*CW-1:0] xx_r, yy_r, zz_r;
  logic signed [2*CW-1:0] xx_p, yy_p, zz_p;

  assign xx_p = in_x_coord * in_x_coord;
  assign yy_p = in_y_coord * in_y_coord;
  assign zz_p = in_z_coord * in_z_coord;

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r  <= in_x_coord;
      y_r  <= in_y_coord;
      z_r  <= in_z_coord;
      xx_r <= xx_p;
      yy_r <= yy_p;
      zz_r <= zz_p;
    end
  end

  // stage 2: sums, flags, CORDIC set-up
  logic [2*CW-1:0] hsq, sum_r;
  logic [2*HW-1:0] hv_r;
  logic signed [DW-1:0] xs, zs, ys;
  c2s_pkg::cordic_t pol0_r;
  logic signed [DW-1:0] yb_r;
  c2s_pkg::flags_t fl_nxt, fl_r;

  always_comb begin
    hsq = xx_r + zz_r;
    xs  = DW'(x_r);
    zs  = DW'(z_r);
    ys  = DW'(y_r);
    fl_nxt.x_zero = (x_r == '0);
    fl_nxt.x_neg  = x_r[CW-1];
    fl_nxt.z_zero = (z_r == '0);
    fl_nxt.z_neg  = z_r[CW-1];
    fl_nxt.h_zero = (hsq == '0);
    fl_nxt.y_zero = (y_r == '0);
    fl_nxt.y_neg  = y_r[CW-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r      <= hsq + yy_r;
      hv_r       <= (2*HW)'(hsq) << (2*G);
      pol0_r.a   <= (x_r[CW-1] ? -xs : xs) <<< G;
      pol0_r.b   <= (x_r[CW-1] ? -zs : zs) <<< G;
      pol0_r.acc <= '0;
      yb_r       <= ys <<< G;
      fl_r       <= fl_nxt;
    end
  end

  // radius root chain
  logic [2*CW-1:0] rv  [0:CW];
  logic [CW+2:0]   rr  [0:CW];
  logic [CW-1:0]   rq  [0:CW];

  assign rv[0] = sum_r;
  assign rr[0] = '0;
  assign rq[0] = '0;

  for (genvar i = 0; i < CW; i++) begin : g_rad
    c2s_sqrt_cell #(.W(CW)) u_cell (
      .clk(clk), .en(adv),
      .v_i(rv[i]), .rem_i(rr[i]), .root_i(rq[i]),
      .v_o(rv[i+1]), .rem_o(rr[i+1]), .root_o(rq[i+1])
    );
  end

  logic [CW+2:0] rad_rem;
  logic [CW-1:0] rad_root;

  c2s_delay #(.WIDTH(2*CW+3), .DEPTH(RDLY)) u_rad_dly (
    .clk(clk), .en(adv), .d_i({rq[CW], rr[CW]}), .d_o({rad_root, rad_rem})
  );

  // horizontal length root chain
  logic [2*HW-1:0] hvv [0:HW];
  logic [HW+2:0]   hr  [0:HW];
  logic [HW-1:0]   hq  [0:HW];

  assign hvv[0] = hv_r;
  assign hr[0]  = '0;
  assign hq[0]  = '0;

  for (genvar i = 0; i < HW; i++) begin : g_hlen
    c2s_sqrt_cell #(.W(HW)) u_cell (
      .clk(clk), .en(adv),
      .v_i(hvv[i]), .rem_i(hr[i]), .root_i(hq[i]),
      .v_o(hvv[i+1]), .rem_o(hr[i+1]), .root_o(hq[i+1])
    );
  end

  logic signed [DW-1:0] yb_d;

  c2s_delay #(.WIDTH(DW), .DEPTH(HW)) u_yb_dly (
    .clk(clk), .en(adv), .d_i(yb_r), .d_o(yb_d)
  );

  // polar CORDIC chain
  c2s_pkg::cordic_t pst [0:NC];
  assign pst[0] = pol0_r;

  for (genvar i = 0; i < NC; i++) begin : g_pol
    c2s_cordic_cell #(.IDX(i)) u_cell (
      .clk(clk), .en(adv), .st_i(pst[i]), .st_o(pst[i+1])
    );
  end

  logic signed [AW-1:0] pacc_d;

  c2s_delay #(.WIDTH(AW), .DEPTH(HW)) u_pol_dly (
    .clk(clk), .en(adv), .d_i(pst[NC].acc), .d_o(pacc_d)
  );

  // elevation CORDIC chain
  c2s_pkg::cordic_t est [0:NC];

  assign est[0] = '{a: DW'(hq[HW]), b: yb_d, acc: '0};

  for (genvar i = 0; i < NC; i++) begin : g_elev
    c2s_cordic_cell #(.IDX(i)) u_cell (
      .clk(clk), .en(adv), .st_i(est[i]), .st_o(est[i+1])
    );
  end

  c2s_pkg::flags_t fl_d;

  c2s_delay #(.WIDTH($bits(c2s_pkg::flags_t)), .DEPTH(MID)) u_fl_dly (
    .clk(clk), .en(adv), .d_i(fl_r), .d_o(fl_d)
  );

  // final stage
  logic [AW-1:0] pt, et;
  logic signed [16:0] p17, e17, pcl;
  logic signed [17:0] pwr;
  logic [CW-1:0] rad_nxt, fin_rad_r;
  logic signed [16:0] pol_nxt, fin_pol_r;
  logic signed [15:0] elv_nxt, fin_elv_r;
  logic deg_nxt, fin_deg_r;

  always_comb begin
    pt  = pacc_d + c2s_pkg::ROUND_HALF;
    et  = est[NC].acc + c2s_pkg::ROUND_HALF;
    p17 = pt[AW-1:16];
    e17 = et[AW-1:16];

    if (p17 > c2s_pkg::QUARTER_M1) begin
      pcl = c2s_pkg::QUARTER_M1;
    end else if (p17 < -c2s_pkg::QUARTER_M1) begin
      pcl = -c2s_pkg::QUARTER_M1;
    end else begin
      pcl = p17;
    end
    if (fl_d.z_zero) begin
      pcl = '0;
    end
    pwr = fl_d.x_neg ? (18'(pcl) + c2s_pkg::HALF_TURN) : 18'(pcl);

    if (fl_d.x_zero) begin
      if (fl_d.z_zero) begin
        pol_nxt = '0;
      end else if (fl_d.z_neg) begin
        pol_nxt = -c2s_pkg::QUARTER_TURN;
      end else begin
        pol_nxt = c2s_pkg::QUARTER_TURN;
      end
    end else begin
      pol_nxt = pwr[16:0];
    end

    deg_nxt = 1'b0;
    if (fl_d.h_zero) begin
      if (fl_d.y_zero) begin
        elv_nxt = '0;
        deg_nxt = 1'b1;
      end else if (fl_d.y_neg) begin
        elv_nxt = 16'(-c2s_pkg::QUARTER_TURN);
      end else begin
        elv_nxt = 16'(c2s_pkg::QUARTER_TURN);
      end
    end else if (fl_d.y_zero) begin
      elv_nxt = '0;
    end else begin
      elv_nxt = e17[15:0];
    end

    rad_nxt = (rad_rem > (CW+3)'(rad_root)) ? rad_root + 1'b1 : rad_root;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_rad_r <= rad_nxt;
      fin_pol_r <= pol_nxt;
      fin_elv_r <= elv_nxt;
      fin_deg_r <= deg_nxt;
    end
  end

  // output register and skid stage
  logic out_v_r, out_free;
  logic [CW-1:0] out_rad_r, skid_rad_r;
  logic signed [16:0] out_pol_r, skid_pol_r;
  logic signed [15:0] out_elv_r, skid_elv_r;
  logic out_deg_r, skid_deg_r;

  assign out_free = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= vld_r[LAT-1];
      end
    end else if (vld_r[LAT-1] && adv) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_v_r) begin
        out_rad_r <= skid_rad_r;
        out_pol_r <= skid_pol_r;
        out_elv_r <= skid_elv_r;
        out_deg_r <= skid_deg_r;
      end else begin
        out_rad_r <= fin_rad_r;
        out_pol_r <= fin_pol_r;
        out_elv_r <= fin_elv_r;
        out_deg_r <= fin_deg_r;
      end
    end else if (adv) begin
      skid_rad_r <= fin_rad_r;
      skid_pol_r <= fin_pol_r;
      skid_elv_r <= fin_elv_r;
      skid_deg_r <= fin_deg_r;
    end
  end

  assign out_valid           = out_v_r;
  assign out_radius          = out_rad_r;
  assign out_polar_angle     = out_pol_r;
  assign out_elevation_angle = out_elv_r;
  assign out_degenerate      = out_deg_r;

endmodule

@@ tb/c2s_scoreboard.sv @@
// c2s_scoreboard: watches both channels of cartesian_to_spherical, predicts each
// point's radius by integer square root and its angles by integer CORDIC; counts mismatches.
// Depends on nothing beyond the port widths of the block.
`timescale 1ns / 1ps
module c2s_scoreboard (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_x_coord,
  input  logic signed [15:0] in_y_coord,
  input  logic signed [15:0] in_z_coord,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [15:0]        out_radius,
  input  logic signed [16:0] out_polar_angle,
  input  logic signed [15:0] out_elevation_angle,
  input  logic               out_degenerate,
  output int                 errors,
  output int                 pending
);
  localparam int SHIFT = 16;
  localparam longint QTR = 16384;

  typedef struct packed {
    logic [15:0]        radius;
    logic signed [16:0] polar;
    logic signed [15:0] elev;
    logic               degen;
  } sph_t;

  sph_t expected_q[$];

  longint atan_lut [0:29] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1
  };

  function automatic longint root_floor(longint unsigned v);
    longint unsigned rem, res, bit_w;
    rem = v;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > rem) bit_w >>= 2;
    while (bit_w != 0) begin
      if (rem >= res + bit_w) begin
        rem -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint rotate_angle(longint a, longint b);
    longint acc, da, db;
    acc = 0;
    if (b == 0) return 0;
    for (int i = 0; i < 30; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b >= 0) begin
        a += da; b -= db; acc += atan_lut[i];
      end else begin
        a -= da; b += db; acc -= atan_lut[i];
      end
    end
    return (acc + 32768) >>> 16;
  endfunction

  function automatic sph_t to_spherical(longint x, longint y, longint z);
    sph_t s;
    longint hsq, total, r, polar, elev, ax, bz;
    hsq = x * x + z * z;
    total = hsq + y * y;
    r = root_floor(total);
    if (total - r * r > r) r++;
    s.degen = 1'b0;
    if (x == 0) begin
      polar = (z > 0) ? QTR : (z < 0) ? -QTR : 0;
    end else begin
      ax = (x < 0) ? -x : x;
      bz = (x < 0) ? -z : z;
      polar = rotate_angle(ax <<< SHIFT, bz <<< SHIFT);
      if (polar > QTR - 1) polar = QTR - 1;
      if (polar < -(QTR - 1)) polar = -(QTR - 1);
      if (x < 0) polar += 2 * QTR;
    end
    if (hsq == 0) begin
      elev = (y > 0) ? QTR : (y < 0) ? -QTR : 0;
      s.degen = (y == 0);
    end else begin
      elev = rotate_angle(root_floor(hsq <<< (2 * SHIFT)), y <<< SHIFT);
    end
    s.radius = r[15:0];
    s.polar = polar[16:0];
    s.elev = elev[15:0];
    return s;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    sph_t want;
    if (rst_n && in_valid && in_ready)
      expected_q.push_back(to_spherical(in_x_coord, in_y_coord, in_z_coord));
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat radius", out_radius, -1);
      end else begin
        want = expected_q.pop_front();
        if (out_radius !== want.radius)
          report_mismatch("radius", out_radius, want.radius);
        if (out_polar_angle !== want.polar)
          report_mismatch("polar", out_polar_angle, want.polar);
        if (out_elevation_angle !== want.elev)
          report_mismatch("elevation", out_elevation_angle, want.elev);
        if (out_degenerate !== want.degen)
          report_mismatch("degenerate", out_degenerate, want.degen);
      end
    end
    pending = expected_q.size();
  end
endmodule

@@ tb/tb_cartesian_to_spherical.sv @@
// tb_cartesian_to_spherical: drives points into cartesian_to_spherical with random
// idling on both sides; c2s_scoreboard checks every result beat.
`timescale 1ns / 1ps
module tb_cartesian_to_spherical;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_x_coord = '0, in_y_coord = '0, in_z_coord = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_radius;
  logic signed [16:0] out_polar_angle;
  logic signed [15:0] out_elevation_angle;
  logic out_degenerate;
  int errors, pending;
  int cycle_no = 0;
  bit calm;

  always #5 clk = ~clk;

  cartesian_to_spherical dut (.*);

  c2s_scoreboard checker_i (.*);

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 22);
  end

  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'($signed($urandom_range(8)) - 4);
      4: return 16'($signed($urandom_range(512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_coord <= x;
    in_y_coord <= y;
    in_z_coord <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    logic signed [15:0] ext [0:4];
    ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001, 16'shffff};
    calm = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_point(0, 0, 0);
    send_point(0, 5, 0);
    send_point(0, -5, 0);
    send_point(7, 3, 0);
    send_point(-7, 3, 0);
    send_point(0, 2, 9);
    send_point(0, 2, -9);
    send_point(16'sh8000, 16'sh8000, 16'sh8000);
    send_point(16'sh7fff, 16'sh7fff, 16'sh7fff);
    for (int i = 0; i < 5; i++) send_point(ext[i], ext[(i + 2) % 5], ext[(i + 4) % 5]);
    send_point(1, 0, 16'sh7fff);
    send_point(1, 0, 16'sh8000);
    send_point(-1, 0, 16'sh7fff);
    send_point(-1, 0, 16'sh8000);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    for (int n = 0; n < 1400; n++) begin
      calm = (n >= 500 && n < 700);
      send_point(pick_coord(), pick_coord(), pick_coord());
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
